// ===== design/sspf_pkg.sv =====
// Package with the frame constants and status codes of the servo status frame parser.
`timescale 1ns / 1ps
package sspf_pkg;

	localparam int POS_W       = 5;
	localparam int WORD_W      = 16;
	localparam int WORD_COUNT  = 6;
	localparam int FRAME_BYTES = 23;
	localparam int POS_SAT     = 24;
	localparam int FIRST_WORD  = 6;
	localparam int WORD_STRIDE = 3;

	localparam logic [7:0] SYNC_BYTE = 8'h55;
	localparam logic [7:0] LEN_BYTE  = 8'h15;
	localparam logic [7:0] CMD_BYTE  = 8'h15;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BAD_CMD = 3'd1,
		ST_BAD_LEN = 3'd2,
		ST_BAD_HDR = 3'd3,
		ST_BAD_SIZE = 3'd4
	} status_t;

endpackage

// ===== design/servo_status_frame_parser_top.sv =====
// Servo status frame parser: byte counter, header checks, word capture and result register.
`timescale 1ns / 1ps
// The parser takes one reply byte per cycle on the input channel while in_ready is high,
// and gives one result per frame through the result register, in the cycle after the
// byte marked end_of_frame is taken. in_ready drops only while a finished result sits
// in the result register and out_ready is low, and a result that is taken in the same
// cycle frees the register for the next one. A frame that is not exactly 23 bytes long
// reports a wrong size, and any error status zeroes the gripper and joint codes.
module servo_status_frame_parser_top
	import sspf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic                end_of_frame,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          status,
	output logic [WORD_W-1:0]   gripper_code,
	output logic [WORD_W-1:0]   joint_1,
	output logic [WORD_W-1:0]   joint_2,
	output logic [WORD_W-1:0]   joint_3,
	output logic [WORD_W-1:0]   joint_4,
	output logic [WORD_W-1:0]   joint_5
);

	logic [POS_W-1:0]  pos_q;
	logic              hdr_bad_q;
	logic              len_bad_q;
	logic              cmd_bad_q;
	logic [WORD_W-1:0] words_q [WORD_COUNT];

	logic [POS_W-1:0]  count_n;
	logic              hdr_bad_n;
	logic              len_bad_n;
	logic              cmd_bad_n;
	logic [WORD_W-1:0] words_n [WORD_COUNT];
	status_t           status_n;

	logic              out_valid_q;
	status_t           status_q;
	logic [WORD_W-1:0] result_q [WORD_COUNT];

	logic              accept;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		hdr_bad_n = hdr_bad_q ||
			((pos_q == POS_W'(0) || pos_q == POS_W'(1)) && data_byte != SYNC_BYTE);
		len_bad_n = len_bad_q || (pos_q == POS_W'(2) && data_byte != LEN_BYTE);
		cmd_bad_n = cmd_bad_q || (pos_q == POS_W'(3) && data_byte != CMD_BYTE);
		count_n   = (pos_q < POS_W'(POS_SAT)) ? pos_q + POS_W'(1) : POS_W'(POS_SAT);
	end

	// Word k takes its low byte at offset 6+3k and its high byte one offset later.
	for (genvar k = 0; k < WORD_COUNT; k++) begin : g_word
		localparam logic [POS_W-1:0] LO_POS = POS_W'(FIRST_WORD + WORD_STRIDE * k);
		always_comb begin
			words_n[k] = words_q[k];
			if (pos_q == LO_POS) begin
				words_n[k][7:0] = data_byte;
			end else if (pos_q == LO_POS + POS_W'(1)) begin
				words_n[k][15:8] = data_byte;
			end
		end
	end

	always_comb begin
		if (count_n != POS_W'(FRAME_BYTES)) begin
			status_n = ST_BAD_SIZE;
		end else if (hdr_bad_n) begin
			status_n = ST_BAD_HDR;
		end else if (len_bad_n) begin
			status_n = ST_BAD_LEN;
		end else if (cmd_bad_n) begin
			status_n = ST_BAD_CMD;
		end else begin
			status_n = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			hdr_bad_q <= 1'b0;
			len_bad_q <= 1'b0;
			cmd_bad_q <= 1'b0;
		end else if (accept) begin
			if (end_of_frame) begin
				pos_q     <= '0;
				hdr_bad_q <= 1'b0;
				len_bad_q <= 1'b0;
				cmd_bad_q <= 1'b0;
			end else begin
				pos_q     <= count_n;
				hdr_bad_q <= hdr_bad_n;
				len_bad_q <= len_bad_n;
				cmd_bad_q <= cmd_bad_n;
			end
		end
	end

	// An ok status needs all 23 bytes of this frame, so every word is rewritten first.
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < WORD_COUNT; i++) begin
				words_q[i] <= words_n[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && end_of_frame) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && end_of_frame) begin
			status_q <= status_n;
			for (int i = 0; i < WORD_COUNT; i++) begin
				result_q[i] <= (status_n == ST_OK) ? words_n[i] : '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign gripper_code = result_q[0];
	assign joint_1      = result_q[1];
	assign joint_2      = result_q[2];
	assign joint_3      = result_q[3];
	assign joint_4      = result_q[4];
	assign joint_5      = result_q[5];

endmodule

// ===== design/sspf_checker.sv =====
// Port-level checker for the servo status frame parser, bound to the top level.
`timescale 1ns / 1ps
module sspf_checker
	import sspf_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        end_of_frame,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [15:0] gripper_code,
	input logic [15:0] joint_1,
	input logic [15:0] joint_2,
	input logic [15:0] joint_3,
	input logic [15:0] joint_4,
	input logic [15:0] joint_5
);

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(gripper_code)
			&& $stable(joint_5))
		else $error("result changed while stalled");

	// Every accepted last byte of a frame yields a result in the next cycle.
	a_eof_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && end_of_frame |=> out_valid)
		else $error("no result after end of frame");

	// A new result only appears after an accepted last byte.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid && !out_ready) |->
			$past(in_valid && in_ready && end_of_frame))
		else $error("result without end of frame");

	// Any error status clears every value field.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |->
			gripper_code == 16'h0 && joint_1 == 16'h0 && joint_2 == 16'h0 &&
			joint_3 == 16'h0 && joint_4 == 16'h0 && joint_5 == 16'h0)
		else $error("value fields not zero on error");

endmodule

bind servo_status_frame_parser_top sspf_checker u_sspf_checker (.*);

// ===== sim/sspf_reply_checker.sv =====
// Checker that predicts and compares the replies of the servo status frame parser.
`timescale 1ns / 1ps
module sspf_reply_checker
	import sspf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              end_of_frame,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [2:0]        status,
	input  logic [WORD_W-1:0] gripper_code,
	input  logic [WORD_W-1:0] joint_1,
	input  logic [WORD_W-1:0] joint_2,
	input  logic [WORD_W-1:0] joint_3,
	input  logic [WORD_W-1:0] joint_4,
	input  logic [WORD_W-1:0] joint_5,
	output int                failures,
	output int                pending
);

	typedef struct packed {
		status_t                         status;
		logic [WORD_COUNT-1:0][WORD_W-1:0] codes;
	} reply_t;

	reply_t            expected_replies[$];
	logic [POS_W-1:0]  seen_bytes;
	logic              hdr_bad;
	logic              len_bad;
	logic              cmd_bad;
	logic [WORD_W-1:0] word_buf [WORD_COUNT];
	int                fail_total = 0;
	int                queued = 0;

	assign failures = fail_total;
	assign pending  = queued;

	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		$display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
		fail_total++;
	endtask

	task automatic clear_frame_state();
		seen_bytes = '0;
		hdr_bad    = 1'b0;
		len_bad    = 1'b0;
		cmd_bad    = 1'b0;
		for (int i = 0; i < WORD_COUNT; i++)
			word_buf[i] = '0;
	endtask

	task automatic parse_reply_byte(input logic [7:0] b, input logic last);
		int     pos;
		int     rel;
		reply_t r;
		pos = seen_bytes;
		if ((pos == 0 || pos == 1) && b != SYNC_BYTE)
			hdr_bad = 1'b1;
		if (pos == 2 && b != LEN_BYTE)
			len_bad = 1'b1;
		if (pos == 3 && b != CMD_BYTE)
			cmd_bad = 1'b1;
		if (pos >= FIRST_WORD && pos < FIRST_WORD + WORD_COUNT * WORD_STRIDE) begin
			rel = pos - FIRST_WORD;
			// The third byte of each group is an ID byte and is skipped.
			if (rel % WORD_STRIDE == 0)
				word_buf[rel / WORD_STRIDE][7:0] = b;
			else if (rel % WORD_STRIDE == 1)
				word_buf[rel / WORD_STRIDE][15:8] = b;
		end
		seen_bytes = (pos < POS_SAT) ? POS_W'(pos + 1) : POS_W'(POS_SAT);
		if (last) begin
			if (seen_bytes != FRAME_BYTES)
				r.status = ST_BAD_SIZE;
			else if (hdr_bad)
				r.status = ST_BAD_HDR;
			else if (len_bad)
				r.status = ST_BAD_LEN;
			else if (cmd_bad)
				r.status = ST_BAD_CMD;
			else
				r.status = ST_OK;
			for (int i = 0; i < WORD_COUNT; i++)
				r.codes[i] = (r.status == ST_OK) ? word_buf[i] : '0;
			expected_replies = {expected_replies, r};
			clear_frame_state();
		end
	endtask

	task automatic check_reply();
		reply_t want;
		if (expected_replies.size() == 0) begin
			report_mismatch("unexpected reply", {13'd0, status}, '0);
		end else begin
			want = expected_replies.pop_front();
			if (status !== want.status)
				report_mismatch("status", {13'd0, status}, {13'd0, want.status});
			if (gripper_code !== want.codes[0])
				report_mismatch("gripper_code", gripper_code, want.codes[0]);
			if (joint_1 !== want.codes[1])
				report_mismatch("joint_1", joint_1, want.codes[1]);
			if (joint_2 !== want.codes[2])
				report_mismatch("joint_2", joint_2, want.codes[2]);
			if (joint_3 !== want.codes[3])
				report_mismatch("joint_3", joint_3, want.codes[3]);
			if (joint_4 !== want.codes[4])
				report_mismatch("joint_4", joint_4, want.codes[4]);
			if (joint_5 !== want.codes[5])
				report_mismatch("joint_5", joint_5, want.codes[5]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame_state();
			expected_replies.delete();
		end else begin
			// A reply leaving now was caused by an earlier byte, so it is matched first.
			if (out_valid && out_ready)
				check_reply();
			if (in_valid && in_ready)
				parse_reply_byte(data_byte, end_of_frame);
		end
		queued = expected_replies.size();
	end

endmodule

// ===== sim/tb_servo_status_frame_parser_top.sv =====
// Testbench top that drives frames into the servo status frame parser and gives the verdict.
`timescale 1ns / 1ps
module tb_servo_status_frame_parser_top
	import sspf_pkg::*;
();

	typedef enum int {
		RX_ALWAYS,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	localparam int IDLE_LIMIT   = 5000;
	localparam int RANDOM_BYTES = 1700;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic [7:0]        data_byte = 8'h00;
	logic              end_of_frame = 1'b0;
	logic              out_ready = 1'b0;
	logic              in_ready;
	logic              out_valid;
	logic [2:0]        status;
	logic [WORD_W-1:0] gripper_code;
	logic [WORD_W-1:0] joint_1;
	logic [WORD_W-1:0] joint_2;
	logic [WORD_W-1:0] joint_3;
	logic [WORD_W-1:0] joint_4;
	logic [WORD_W-1:0] joint_5;
	int                failures;
	int                pending;

	logic [7:0]        frame_buf [0:63];
	int                bytes_sent = 0;
	int                burst_left = 0;
	int                idle_cycles = 0;
	rx_mode_t          rx_mode = RX_ALWAYS;
	int                rx_phase_left = 0;
	int                rx_cycle = 0;

	servo_status_frame_parser_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.end_of_frame (end_of_frame),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.gripper_code (gripper_code),
		.joint_1      (joint_1),
		.joint_2      (joint_2),
		.joint_3      (joint_3),
		.joint_4      (joint_4),
		.joint_5      (joint_5)
	);

	sspf_reply_checker reply_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.end_of_frame (end_of_frame),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.gripper_code (gripper_code),
		.joint_1      (joint_1),
		.joint_2      (joint_2),
		.joint_3      (joint_3),
		.joint_4      (joint_4),
		.joint_5      (joint_5),
		.failures     (failures),
		.pending      (pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// The result side changes its stall behavior at the end of each phase of random length.
	always @(posedge clk) begin
		if (rx_phase_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_phase_left <= $urandom_range(20, 300);
		end else begin
			rx_phase_left <= rx_phase_left - 1;
		end
		rx_cycle <= rx_cycle + 1;
		case (rx_mode)
			RX_ALWAYS:   out_ready <= 1'b1;
			RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
			default:     out_ready <= (rx_cycle % 3 != 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic logic [7:0] other_than(input logic [7:0] good);
		return good ^ 8'($urandom_range(1, 255));
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
				: $urandom_range(1, 40);
		end
		in_valid     <= 1'b1;
		data_byte    <= b;
		end_of_frame <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_frame(input int len);
		for (int i = 0; i < len; i++)
			send_byte(frame_buf[i], i == len - 1);
	endtask

	// Bits of bad_mask spoil header byte 0, header byte 1, the length byte and the command
	// byte, in that order. Every other byte is random.
	task automatic build_frame(input int len, input logic [3:0] bad_mask);
		for (int i = 0; i < len; i++)
			frame_buf[i] = 8'($urandom_range(0, 255));
		frame_buf[0] = bad_mask[0] ? other_than(SYNC_BYTE) : SYNC_BYTE;
		frame_buf[1] = bad_mask[1] ? other_than(SYNC_BYTE) : SYNC_BYTE;
		frame_buf[2] = bad_mask[2] ? other_than(LEN_BYTE) : LEN_BYTE;
		frame_buf[3] = bad_mask[3] ? other_than(CMD_BYTE) : CMD_BYTE;
	endtask

	initial begin
		int         pick;
		int         len;
		logic [3:0] mask;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// A frame of a single byte.
		frame_buf[0] = 8'hFF;
		send_frame(1);

		// A good frame with all-zero and all-one words.
		build_frame(FRAME_BYTES, 4'b0000);
		for (int i = 0; i < WORD_COUNT; i++) begin
			frame_buf[FIRST_WORD + WORD_STRIDE * i]     = (i % 2 == 0) ? 8'h00 : 8'hFF;
			frame_buf[FIRST_WORD + WORD_STRIDE * i + 1] = (i % 2 == 0) ? 8'h00 : 8'hFF;
		end
		send_frame(FRAME_BYTES);

		// Header byte 1, the length byte and the command byte all bad: the header error must win.
		build_frame(FRAME_BYTES, 4'b1110);
		send_frame(FRAME_BYTES);

		// One byte too many with a clean header.
		build_frame(FRAME_BYTES + 1, 4'b0000);
		send_frame(FRAME_BYTES + 1);

		while (bytes_sent < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			mask = $urandom_range(0, 1) ? 4'b0000 : 4'($urandom_range(1, 15));
			if (pick < 55) begin
				len = FRAME_BYTES;
				build_frame(len, mask);
			end else if (pick < 70) begin
				len = $urandom_range(1, FRAME_BYTES - 1);
				build_frame(len, mask);
			end else if (pick < 82) begin
				len = $urandom_range(FRAME_BYTES + 1, 40);
				build_frame(len, mask);
			end else begin
				len = $urandom_range(1, 30);
				for (int i = 0; i < len; i++)
					frame_buf[i] = 8'($urandom_range(0, 255));
			end
			send_frame(len);
		end
		in_valid <= 1'b0;

		// The checker counts the last request at the edge it was taken on, so look after the next edge.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
design/sspf_pkg.sv
design/servo_status_frame_parser_top.sv
design/sspf_checker.sv
sim/sspf_reply_checker.sv
sim/tb_servo_status_frame_parser_top.sv
